// ===== rtl/bba_pkg.sv =====
// Shared types and constants for the buddy block allocator.
// No dependencies.
`timescale 1ns / 1ps
package bba_pkg;
  localparam int MaxBlocks = 64;
  localparam int IdxW = $clog2(MaxBlocks);
  localparam int CntW = IdxW + 1;
  localparam int PowW = 5;
  localparam int OwnW = 16;
  localparam int SizeW = 31;
  localparam int ExpW = 6;
  localparam logic [PowW-1:0] ResetPower = 5'd10;

  typedef enum logic [1:0] {
    ST_ALLOCATED = 2'd0,
    ST_NO_FIT    = 2'd1,
    ST_FULL      = 2'd2,
    ST_QUERY     = 2'd3
  } status_t;

  typedef struct packed {
    logic            is_query;
    logic [OwnW-1:0] owner;
    logic [ExpW-1:0] power;
  } cmd_t;

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_FIND_RD, S_FIND, S_CHECK, S_SHIFT_RD, S_SHIFT_WR,
    S_SPLIT, S_TAKE, S_RESULT, S_Q_RD, S_Q_WAIT, S_Q_OUT
  } state_t;
endpackage

// ===== rtl/buddy_block_allocator.sv =====
// Top level of the buddy block allocator.
// Depends on bba_pkg, bba_front, bba_back and bba_ram.
//
// Items arrive on the in channel (valid/ready) and are queued, two deep,
// after their size exponent is worked out. The back end handles one item at
// a time. An allocation scans the list one entry at a time, reading each
// entry (S_FIND_RD) and testing it (S_FIND); each split then shifts the tail
// of the list one entry at a time through S_SPLIT and S_SHIFT_WR. A query
// gives one transfer per block, each read via S_Q_RD, S_Q_WAIT and S_Q_OUT.
// Results leave through an output register; while the receiver stalls the
// back end waits, and the front queue keeps taking items until full.
// Reset gives one free block of 2^10 units, which the S_INIT state writes into
// the table. A write on the cfg channel, taken only while idle, sets the
// total size exponent and rebuilds the list as one free block.
`timescale 1ns / 1ps
module buddy_block_allocator import bba_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             req_type,
  input  logic [OwnW-1:0]  owner_id,
  input  logic [SizeW-1:0] request_size,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [PowW-1:0]  total_size_power,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [1:0]       status,
  output logic [CntW-1:0]  block_count,
  output logic [OwnW-1:0]  owner_of_block,
  output logic             last_result
);
  logic cmd_valid, cmd_ready;
  cmd_t cmd;

  bba_front u_front (
    .clk, .rst, .in_valid, .in_ready, .req_type, .owner_id, .request_size,
    .cmd_valid, .cmd_ready, .cmd);

  bba_back u_back (
    .clk, .rst, .cfg_valid, .cfg_ready, .cfg_data(total_size_power),
    .cmd_valid, .cmd_ready, .cmd, .out_valid, .out_ready, .status,
    .block_count, .owner_of_block, .last_result);
endmodule

// ===== rtl/bba_ram.sv =====
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module bba_ram #(
  parameter int Width = 8,
  parameter int Depth = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== rtl/bba_front.sv =====
// Front end: accepts items, works out the size exponent and queues commands.
// Depends on bba_pkg.
`timescale 1ns / 1ps
module bba_front import bba_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             req_type,
  input  logic [OwnW-1:0]  owner_id,
  input  logic [SizeW-1:0] request_size,
  output logic             cmd_valid,
  input  logic             cmd_ready,
  output cmd_t             cmd
);
  cmd_t            q [2];
  logic            wp, rp;
  logic [1:0]      cnt;
  logic [ExpW-1:0] p;
  logic            push, pop;

  // Smallest p with 2^p >= size: bit length of (size - 1).
  always_comb begin
    logic [SizeW-1:0] m;
    m = (request_size == '0) ? '0 : request_size - 1'b1;
    p = '0;
    for (int i = 0; i < SizeW; i++) begin
      if (m[i]) begin
        p = ExpW'(i + 1);
      end
    end
  end

  assign in_ready  = (cnt != 2'd2);
  assign cmd_valid = (cnt != 2'd0);
  assign cmd       = q[rp];
  assign push      = in_valid && in_ready;
  assign pop       = cmd_valid && cmd_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      q[wp] <= '{is_query: req_type, owner: owner_id, power: p};
    end
    if (rst) begin
      wp <= 1'b0;
      rp <= 1'b0;
      cnt <= '0;
    end else begin
      if (push) wp <= ~wp;
      if (pop) rp <= ~rp;
      cnt <= cnt + {1'b0, push} - {1'b0, pop};
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst) cnt != 2'd3)
    else $error("queue count out of range");
  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    cnt == 2'd2 |-> !push) else $error("push into a full queue");
  a_pop_valid: assert property (@(posedge clk) disable iff (rst)
    pop |-> cnt != 2'd0) else $error("pop from an empty queue");
endmodule

// ===== rtl/bba_back.sv =====
// Back end: scans, splits and lists the block table held in two RAMs.
// Depends on bba_pkg and bba_ram.
`timescale 1ns / 1ps
module bba_back import bba_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic [PowW-1:0] cfg_data,
  input  logic            cmd_valid,
  output logic            cmd_ready,
  input  cmd_t            cmd,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [1:0]      status,
  output logic [CntW-1:0] block_count,
  output logic [OwnW-1:0] owner_of_block,
  output logic            last_result
);
  state_t          state, state_next;
  logic [PowW-1:0] total_power;
  logic [CntW-1:0] len;
  logic [IdxW-1:0] idx;
  logic [CntW-1:0] j;
  logic [IdxW-1:0] b;
  logic            have_larger;
  logic [IdxW-1:0] larger_idx;
  cmd_t            cur;
  logic [PowW-1:0] b_pow;

  logic            we;
  logic [IdxW-1:0] waddr, raddr;
  logic [PowW-1:0] wpow, rpow;
  logic [OwnW-1:0] wown, rown;

  bba_ram #(.Width(PowW), .Depth(MaxBlocks)) u_pow (
    .clk, .we, .waddr, .wdata(wpow), .raddr, .rdata(rpow));
  bba_ram #(.Width(OwnW), .Depth(MaxBlocks)) u_own (
    .clk, .we, .waddr, .wdata(wown), .raddr, .rdata(rown));

  logic [IdxW-1:0] jm1;
  assign jm1 = j[IdxW-1:0] - 1'b1;
  assign cfg_ready = (state == S_IDLE) && !out_valid;
  assign cmd_ready = (state == S_IDLE) && !out_valid && !cfg_valid;

  always_comb begin
    state_next = state;
    we = 1'b0;
    waddr = '0;
    wpow = '0;
    wown = '0;
    raddr = idx;
    case (state)
      S_INIT: begin
        we = 1'b1;
        wpow = total_power;
        state_next = S_IDLE;
      end
      S_IDLE: begin
        if (cfg_valid && cfg_ready) begin
          state_next = S_INIT;
        end else if (cmd_valid && cmd_ready) begin
          state_next = cmd.is_query ? S_Q_RD : S_FIND_RD;
        end
      end
      S_FIND_RD: state_next = S_FIND;
      S_FIND: begin
        if (rown == '0 && {1'b0, rpow} == cur.power) begin
          state_next = S_TAKE;
        end else if ({1'b0, idx} + 1'b1 >= len) begin
          state_next = S_CHECK;
        end else begin
          state_next = S_FIND_RD;
        end
      end
      S_CHECK: begin
        if (!have_larger) begin
          state_next = S_RESULT;
        end else if (len + CntW'(b_pow) - CntW'(cur.power) > CntW'(MaxBlocks)) begin
          state_next = S_RESULT;
        end else begin
          state_next = S_SPLIT;
        end
      end
      S_SPLIT: begin
        if ({1'b0, b_pow} == cur.power) begin
          state_next = S_TAKE;
        end else if (j > {1'b0, b} + 1'b1) begin
          raddr = jm1;
          state_next = S_SHIFT_WR;
        end else begin
          we = 1'b1;
          waddr = b + 1'b1;
          wpow = b_pow - 1'b1;
          state_next = S_SPLIT;
        end
      end
      S_SHIFT_WR: begin
        we = 1'b1;
        waddr = j[IdxW-1:0];
        wpow = rpow;
        wown = rown;
        state_next = S_SPLIT;
      end
      S_TAKE: begin
        we = 1'b1;
        waddr = b;
        wpow = b_pow;
        wown = cur.owner;
        state_next = S_RESULT;
      end
      S_RESULT: if (!out_valid) state_next = S_IDLE;
      S_Q_RD: state_next = S_Q_WAIT;
      S_Q_WAIT: state_next = S_Q_OUT;
      S_Q_OUT: begin
        if (!out_valid || out_ready) begin
          state_next = ({1'b0, idx} + 1'b1 >= len) ? S_IDLE : S_Q_RD;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
      total_power <= ResetPower;
      len <= CntW'(1);
      out_valid <= 1'b0;
      idx <= '0;
    end else begin
      state <= state_next;
      if (out_valid && out_ready && state != S_Q_OUT) out_valid <= 1'b0;
      case (state)
        S_INIT: len <= CntW'(1);
        S_IDLE: begin
          if (cfg_valid && cfg_ready) begin
            total_power <= cfg_data;
          end else if (cmd_valid && cmd_ready) begin
            cur <= cmd;
            idx <= '0;
            have_larger <= 1'b0;
          end
        end
        S_FIND: begin
          if (rown == '0 && {1'b0, rpow} == cur.power) begin
            b <= idx;
            b_pow <= rpow;
          end else begin
            if (rown == '0 && {1'b0, rpow} > cur.power && !have_larger) begin
              have_larger <= 1'b1;
              larger_idx <= idx;
              b_pow <= rpow;
            end
            idx <= idx + 1'b1;
          end
        end
        S_CHECK: begin
          b <= larger_idx;
          j <= len;
          if (!have_larger) begin
            status <= ST_NO_FIT;
          end else if (len + CntW'(b_pow) - CntW'(cur.power) > CntW'(MaxBlocks)) begin
            status <= ST_FULL;
          end
        end
        S_SPLIT: begin
          if ({1'b0, b_pow} != cur.power && !(j > {1'b0, b} + 1'b1)) begin
            b_pow <= b_pow - 1'b1;
            len <= len + 1'b1;
            j <= len + 1'b1;
          end
        end
        S_SHIFT_WR: j <= j - 1'b1;
        S_TAKE: status <= ST_ALLOCATED;
        S_RESULT: begin
          if (!out_valid) begin
            out_valid <= 1'b1;
            block_count <= len;
            owner_of_block <= '0;
            last_result <= 1'b1;
          end
        end
        S_Q_OUT: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            status <= ST_QUERY;
            block_count <= len;
            owner_of_block <= rown;
            last_result <= ({1'b0, idx} + 1'b1 >= len);
            idx <= idx + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    len <= CntW'(MaxBlocks) && len != '0) else $error("list length out of range");
  a_cfg_idle: assert property (@(posedge clk) disable iff (rst)
    cfg_ready |-> !cmd_ready || !cfg_valid) else $error("config and command together");
  a_len_grow: assert property (@(posedge clk) disable iff (rst)
    state == S_SPLIT && $past(state) != S_CHECK && $past(state) != S_SHIFT_WR
      && $past(state) != S_SPLIT |-> 1'b0) else $error("bad entry into split");
endmodule

// ===== dv/buddy_block_allocator_tb.sv =====
// Self-checking testbench for the buddy block allocator: directed and random
// allocations and list queries, checked against a built-in block list model.
// Depends on bba_pkg and buddy_block_allocator.
`timescale 1ns / 1ps
module buddy_block_allocator_tb;
  import bba_pkg::*;

  typedef struct packed {
    logic             is_query;
    logic [OwnW-1:0]  owner;
    logic [SizeW-1:0] size;
  } request_t;

  typedef struct packed {
    status_t         st;
    logic [CntW-1:0] count;
    logic [OwnW-1:0] owner;
    logic            last;
  } reply_t;

  logic clk, rst;
  logic in_valid, in_ready, req_type;
  logic [OwnW-1:0] owner_id;
  logic [SizeW-1:0] request_size;
  logic cfg_valid, cfg_ready;
  logic [PowW-1:0] total_size_power;
  logic out_valid, out_ready;
  logic [1:0] status;
  logic [CntW-1:0] block_count;
  logic [OwnW-1:0] owner_of_block;
  logic last_result;

  buddy_block_allocator DUT (.*);

  request_t pending_reqs[$];
  reply_t expected_replies[$];
  logic [PowW-1:0] model_power[MaxBlocks];
  logic [OwnW-1:0] model_owner[MaxBlocks];
  int model_len;
  int errors = 0;
  int cycle_count = 0;
  int gap_left = 0;
  int burst_left = 0;
  bit hold_sender = 0;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  task automatic report_mismatch(input string what);
    $display("ERROR at cycle %0d: %s", cycle_count, what);
    errors++;
  endtask

  function automatic void rebuild_list(input logic [PowW-1:0] pw);
    for (int i = 0; i < MaxBlocks; i++) begin
      model_power[i] = '0;
      model_owner[i] = '0;
    end
    model_power[0] = pw;
    model_len = 1;
  endfunction

  function automatic int exponent_of(input logic [SizeW-1:0] sz);
    int p;
    p = 0;
    while (p < 40 && (64'd1 << p) < {33'd0, sz}) p++;
    return p;
  endfunction

  function automatic status_t allocate_block(input logic [OwnW-1:0] own, input int p);
    int b;
    b = -1;
    for (int i = 0; i < model_len; i++) begin
      if (model_owner[i] == 0 && model_power[i] == p) begin
        model_owner[i] = own;
        return ST_ALLOCATED;
      end
    end
    for (int i = 0; i < model_len; i++) begin
      if (model_owner[i] == 0 && model_power[i] > p) begin
        b = i;
        break;
      end
    end
    if (b < 0) return ST_NO_FIT;
    if (model_len + (int'(model_power[b]) - p) > MaxBlocks) return ST_FULL;
    while (model_power[b] > p) begin
      for (int j = model_len; j > b + 1; j--) begin
        model_power[j] = model_power[j-1];
        model_owner[j] = model_owner[j-1];
      end
      model_power[b] = model_power[b] - 1'b1;
      model_power[b+1] = model_power[b];
      model_owner[b+1] = '0;
      model_len++;
    end
    model_owner[b] = own;
    return ST_ALLOCATED;
  endfunction

  function automatic void predict_replies(input request_t r);
    reply_t e;
    if (!r.is_query) begin
      e.st = allocate_block(r.owner, exponent_of(r.size));
      e.count = model_len[CntW-1:0];
      e.owner = '0;
      e.last = 1'b1;
      expected_replies.push_back(e);
    end else begin
      for (int i = 0; i < model_len; i++) begin
        e.st = ST_QUERY;
        e.count = model_len[CntW-1:0];
        e.owner = model_owner[i];
        e.last = (i == model_len - 1);
        expected_replies.push_back(e);
      end
    end
  endfunction

  // Driver: bursts with random gaps; the model is updated at each transfer.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) predict_replies({req_type, owner_id, request_size});
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_reqs.size() > 0 && !hold_sender) begin
          request_t r;
          r = pending_reqs.pop_front();
          in_valid <= 1'b1;
          req_type <= r.is_query;
          owner_id <= r.owner;
          request_size <= r.size;
          if (burst_left > 0) burst_left--;
          else begin
            burst_left = $urandom_range(0, 8);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor and receiver stall pattern.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_replies.size() == 0) begin
          report_mismatch("result transfer with nothing expected");
        end else begin
          reply_t e;
          e = expected_replies.pop_front();
          if (status !== e.st)
            report_mismatch($sformatf("status %0d, expected %0d", status, e.st));
          if (block_count !== e.count)
            report_mismatch($sformatf("block_count %0d, expected %0d", block_count, e.count));
          if (owner_of_block !== e.owner)
            report_mismatch($sformatf("owner %0h, expected %0h", owner_of_block, e.owner));
          if (last_result !== e.last)
            report_mismatch($sformatf("last %0b, expected %0b", last_result, e.last));
        end
      end
      case (cycle_count % 400 < 100 ? 0 : $urandom_range(0, 3))
        0: out_ready <= 1'b1;
        1: out_ready <= 1'b0;
        default: out_ready <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > 10000000) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic wait_drained();
    while (pending_reqs.size() > 0 || in_valid || expected_replies.size() > 0)
      @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  task automatic write_size(input logic [PowW-1:0] pw);
    cfg_valid <= 1'b1;
    total_size_power <= pw;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    rebuild_list(pw);
  endtask

  function automatic request_t alloc_req(input logic [OwnW-1:0] own, input logic [SizeW-1:0] sz);
    return '{is_query: 1'b0, owner: own, size: sz};
  endfunction

  function automatic request_t query_req();
    return '{is_query: 1'b1, owner: OwnW'($urandom), size: SizeW'($urandom)};
  endfunction

  function automatic logic [SizeW-1:0] random_size(input int maxp);
    int p;
    p = $urandom_range(0, maxp);
    if (p == 0) return SizeW'($urandom_range(0, 1));
    return SizeW'((64'd1 << (p - 1)) + 1 + ($urandom % (64'd1 << (p - 1))));
  endfunction

  initial begin
    logic [PowW-1:0] sizes[5];
    rst = 1'b1;
    in_valid = 1'b0;
    req_type = 1'b0;
    owner_id = '0;
    request_size = '0;
    cfg_valid = 1'b0;
    total_size_power = '0;
    out_ready = 1'b0;
    rebuild_list(ResetPower);
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed part at the reset size of 2^10.
    pending_reqs.push_back(query_req());
    pending_reqs.push_back(alloc_req(16'h0001, 0));
    pending_reqs.push_back(alloc_req(16'hFFFF, 1));
    pending_reqs.push_back(alloc_req(16'h0000, 2));
    pending_reqs.push_back(alloc_req(16'h1234, 3));
    pending_reqs.push_back(alloc_req(16'h5555, 512));
    pending_reqs.push_back(alloc_req(16'hAAAA, 1024));
    pending_reqs.push_back(alloc_req(16'h0F0F, 31'h7FFFFFFF));
    pending_reqs.push_back(alloc_req(16'h00F0, 31'h40000000));
    pending_reqs.push_back(query_req());
    hold_sender = 1'b1;
    hold_sender = 1'b0;
    wait_drained();

    // Smallest space, then deep splits of the largest space.
    write_size(5'd0);
    pending_reqs.push_back(alloc_req(16'h0002, 1));
    pending_reqs.push_back(alloc_req(16'h0003, 1));
    pending_reqs.push_back(query_req());
    wait_drained();
    write_size(5'd31);
    for (int i = 0; i < 8; i++) pending_reqs.push_back(alloc_req(OwnW'(16'h0100 + i), 1));
    pending_reqs.push_back(alloc_req(16'h0200, 1));
    pending_reqs.push_back(query_req());
    wait_drained();

    // Random phases over several sizes.
    sizes = '{5'd10, 5'd6, 5'd30, 5'd3, 5'd31};
    foreach (sizes[k]) begin
      write_size(sizes[k]);
      for (int i = 0; i < 40; i++) begin
        if ($urandom_range(0, 5) == 0) pending_reqs.push_back(query_req());
        else pending_reqs.push_back(alloc_req(OwnW'($urandom_range(0, 65535)),
                                              random_size(sizes[k] + 1)));
      end
      pending_reqs.push_back(query_req());
      if (k == 2) begin
        while (pending_reqs.size() > 20) @(posedge clk);
        hold_sender = 1'b1;
        while (in_valid || expected_replies.size() > 0) @(posedge clk);
        hold_sender = 1'b0;
      end
      wait_drained();
    end

    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
